>>> hw/rtl/prt_pkg.sv
// Package for the pair registration table: sizes, opcodes, request and
// result payloads, memory port bundle and controller states.
// No dependencies.
package prt_pkg;

    localparam int CAPACITY = 31;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int OIDX_W   = 5;
    localparam int OCNT_W   = 5;

    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_UNREGISTER = 2'd1,
        OP_LOOKUP     = 2'd2,
        OP_LIST       = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t            opcode;
        logic [KEY_W-1:0]   app_id;
        logic [KEY_W-1:0]   bus_id;
    } req_t;

    typedef struct packed {
        logic               status;
        logic               found;
        logic [OIDX_W-1:0]  entry_index;
        logic [KEY_W-1:0]   match_bus_id;
        logic [OCNT_W-1:0]  entries_used;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]   app;
        logic [KEY_W-1:0]   bus;
    } entry_t;

    typedef struct packed {
        logic               rd_en;
        logic [IDX_W-1:0]   rd_addr;
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        entry_t             wr_data;
    } mem_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINAL,
        ST_MOVE
    } state_t;

endpackage

>>> hw/rtl/prt_pair_ram.sv
// Pair store: CAPACITY entries of (application id, business id), one
// write port and one registered read port. Depends on prt_pkg.
module prt_pair_ram
    import prt_pkg::*;
(
    input  logic     clk,
    input  mem_req_t mem_req,
    output entry_t   rd_data
);

    entry_t mem [CAPACITY];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data_reg <= mem[mem_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/prt_ctrl.sv
// Table controller: scans the pair store one entry a cycle, then appends,
// moves the last entry or reports. Depends on prt_pkg.
module prt_ctrl
    import prt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  req_t     request,
    output logic     strobe,
    output rsp_t     result,
    output mem_req_t mem_req,
    input  entry_t   rd_data
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               rvalid_reg, rvalid_next;
    logic               found_reg, found_next;
    logic               pend_reg, pend_next;
    logic               res_valid_reg, res_valid_next;

    req_t               req_reg, req_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [KEY_W-1:0]   pend_bus_reg, pend_bus_next;
    rsp_t               res_reg, res_next;

    logic               app_hit;
    logic               pair_hit;
    logic [CNT_W-1:0]   last_slot;

    function automatic rsp_t make_rsp(logic st, logic fnd, logic [IDX_W-1:0] idx,
                                      logic [KEY_W-1:0] bus, logic [CNT_W-1:0] used,
                                      logic lst);
        rsp_t r;
        r.status       = st;
        r.found        = fnd;
        r.entry_index  = OIDX_W'(idx);
        r.match_bus_id = bus;
        r.entries_used = OCNT_W'(used);
        r.last         = lst;
        return r;
    endfunction

    assign app_hit   = rd_data.app == req_reg.app_id;
    assign pair_hit  = app_hit && (rd_data.bus == req_reg.bus_id);
    assign last_slot = count_reg - CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            rvalid_reg    <= 1'b0;
            found_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            rvalid_reg    <= rvalid_next;
            found_reg     <= found_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        cmp_idx_reg  <= cmp_idx_next;
        pos_reg      <= pos_next;
        pend_idx_reg <= pend_idx_next;
        pend_bus_reg <= pend_bus_next;
        res_reg      <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        rvalid_next    = 1'b0;
        found_next     = found_reg;
        pend_next      = pend_reg;
        res_valid_next = 1'b0;
        req_next       = req_reg;
        cmp_idx_next   = cmp_idx_reg;
        pos_next       = pos_reg;
        pend_idx_next  = pend_idx_reg;
        pend_bus_next  = pend_bus_reg;
        res_next       = res_reg;
        mem_req        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    issue_next = '0;
                    found_next = 1'b0;
                    pend_next  = 1'b0;
                    pos_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // issue the next read
                if (issue_reg < count_reg)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = issue_reg[IDX_W-1:0];
                    issue_next      = issue_reg + CNT_W'(1);
                    rvalid_next     = 1'b1;
                    cmp_idx_next    = issue_reg[IDX_W-1:0];
                end
                else if (!rvalid_reg)
                begin
                    state_next = ST_FINAL;
                end
                // compare the returned entry
                if (rvalid_reg)
                begin
                    if (req_reg.opcode == OP_LIST)
                    begin
                        if (app_hit)
                        begin
                            if (pend_reg)
                            begin
                                res_valid_next = 1'b1;
                                res_next = make_rsp(1'b0, 1'b1, pend_idx_reg, pend_bus_reg,
                                                    count_reg, 1'b0);
                            end
                            pend_next     = 1'b1;
                            pend_idx_next = cmp_idx_reg;
                            pend_bus_next = rd_data.bus;
                        end
                    end
                    else if (pair_hit && !found_reg)
                    begin
                        found_next = 1'b1;
                        pos_next   = cmp_idx_reg;
                    end
                end
            end
            ST_FINAL:
            begin
                state_next     = ST_IDLE;
                res_valid_next = 1'b1;
                case (req_reg.opcode)
                    OP_REGISTER:
                    begin
                        if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            res_next = make_rsp(1'b1, found_reg, pos_reg, '0, count_reg, 1'b1);
                        end
                        else if (found_reg)
                        begin
                            res_next = make_rsp(1'b0, 1'b1, pos_reg, '0, count_reg, 1'b1);
                        end
                        else
                        begin
                            mem_req.wr_en       = 1'b1;
                            mem_req.wr_addr     = count_reg[IDX_W-1:0];
                            mem_req.wr_data.app = req_reg.app_id;
                            mem_req.wr_data.bus = req_reg.bus_id;
                            count_next          = count_reg + CNT_W'(1);
                            res_next = make_rsp(1'b0, 1'b0, count_reg[IDX_W-1:0], '0,
                                                count_next, 1'b1);
                        end
                    end
                    OP_UNREGISTER:
                    begin
                        if (!found_reg)
                        begin
                            res_next = make_rsp(1'b0, 1'b0, '0, '0, count_reg, 1'b1);
                        end
                        else if (CNT_W'(pos_reg) != last_slot)
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = last_slot[IDX_W-1:0];
                            res_valid_next  = 1'b0;
                            state_next      = ST_MOVE;
                        end
                        else
                        begin
                            count_next = last_slot;
                            res_next   = make_rsp(1'b0, 1'b1, pos_reg, '0, last_slot, 1'b1);
                        end
                    end
                    OP_LOOKUP:
                    begin
                        res_next = make_rsp(1'b0, found_reg, pos_reg, '0, count_reg, 1'b1);
                    end
                    default:
                    begin
                        if (pend_reg)
                        begin
                            res_next = make_rsp(1'b0, 1'b1, pend_idx_reg, pend_bus_reg,
                                                count_reg, 1'b1);
                        end
                        else
                        begin
                            res_next = make_rsp(1'b0, 1'b0, '0, '0, count_reg, 1'b1);
                        end
                    end
                endcase
            end
            ST_MOVE:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pos_reg;
                mem_req.wr_data = rd_data;
                count_next      = last_slot;
                res_valid_next  = 1'b1;
                res_next        = make_rsp(1'b0, 1'b1, pos_reg, '0, last_slot, 1'b1);
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = state_reg != ST_IDLE;
    assign strobe = res_valid_reg;
    assign result = res_reg;

    a_count_with_final: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> (res_valid_reg && res_reg.last))
        else $error("entry count changed without a final result");

    a_partial_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.last) |-> (state_reg == ST_SCAN || state_reg == ST_FINAL))
        else $error("non-final result outside a list scan");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (CNT_W'(mem_req.wr_addr) <= count_reg
                           && count_reg <= CNT_W'(CAPACITY)))
        else $error("write beyond the filled part of the table");

    a_write_ends_op: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |=> (state_reg == ST_IDLE && res_valid_reg))
        else $error("table write not followed by the result");

endmodule

>>> hw/rtl/pair_registration_table_core.sv
// Top level of the pair registration table: controller plus pair store.
// Depends on prt_pkg, prt_pair_ram, prt_ctrl.
//
// Usage:
//   A request (opcode, app_id, bus_id) is taken at a rising edge with start
//   high and busy low. busy stays high until the request's final result is
//   registered.
//   Each result is on result for one cycle with strobe high; the receiver
//   must take it then. result.last marks the final result of a request.
//   Register, unregister and lookup give one result; list gives one result
//   per matching entry in slot order, or one no-match result.
//   A request's length is set by the scan of the single-read-port pair
//   store, one entry a cycle, plus the registered read and the write-back.
//   The final result is on result in the first cycle with busy low.
//   Reset empties the table at once (entry count to zero); no clearing pass.
module pair_registration_table_core
    import prt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic strobe,
    output rsp_t result
);

    mem_req_t mem_req;
    entry_t   rd_data;

    prt_pair_ram u_ram (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    prt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .strobe  (strobe),
        .result  (result),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

endmodule
